// ===== hdl/adjacent_step_array_count_dp_unit_defines.svh =====
// assertion macros for the adjacent-step array counter
// used by the checker bound to the top level; needs clk and rst_n in scope
`ifndef ADJACENT_STEP_ARRAY_COUNT_DP_UNIT_DEFINES_SVH
`define ADJACENT_STEP_ARRAY_COUNT_DP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/asac_pkg.sv =====
// shared types, constants and modular arithmetic for the array counter
// no dependencies
package asac_pkg;

  localparam int          COUNT_W           = 30;
  localparam logic [31:0] COUNT_MOD         = 32'd1000000007;
  localparam logic [31:0] COUNT_MOD_X2      = 32'd2000000014;
  localparam logic [7:0]  VALUE_LIMIT_RESET = 8'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } asac_state_t;

  // one accepted input beat
  typedef struct packed {
    logic [7:0] template_value;
    logic       first_element;
    logic       last_element;
  } asac_item_t;

  // count handed to the output register
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } asac_result_t;

  // (a + b) mod P for a, b below P
  function automatic logic [COUNT_W-1:0] mod_add2(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
    logic [31:0] s;
    s = {2'b00, a} + {2'b00, b};
    if (s >= COUNT_MOD) begin
      s = s - COUNT_MOD;
    end
    return s[COUNT_W-1:0];
  endfunction

  // (a + b + c) mod P for a, b, c below P; sum stays below 3P < 2^32
  function automatic logic [COUNT_W-1:0] mod_sum3(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b,
                                                  input logic [COUNT_W-1:0] c);
    logic [31:0] s;
    logic [31:0] r;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    if (s >= COUNT_MOD_X2) begin
      r = s - COUNT_MOD_X2;
    end else if (s >= COUNT_MOD) begin
      r = s - COUNT_MOD;
    end else begin
      r = s;
    end
    return r[COUNT_W-1:0];
  endfunction

endpackage

// ===== hdl/asac_row_mem.sv =====
// count row storage: one write port, one registered read port
// depends on asac_pkg for the entry width
module asac_row_mem #(
  parameter int DEPTH = 130,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [asac_pkg::COUNT_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [asac_pkg::COUNT_W-1:0] wr_data
);
  import asac_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/asac_step_engine.sv =====
// row update sequencer: walks the count row once per beat, read-modify-write,
// and accumulates the new row for the result; depends on asac_pkg
module asac_step_engine #(
  parameter int MAX_VALUE = 128,
  parameter int AW        = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  asac_pkg::asac_item_t         item,
  input  logic [7:0]                   value_limit,
  input  logic                         slot_free,
  output logic                         idle,
  output asac_pkg::asac_result_t       result,
  output logic                         mem_rd_en,
  output logic [AW-1:0]                mem_rd_addr,
  input  logic [asac_pkg::COUNT_W-1:0] mem_rd_data,
  output logic                         mem_wr_en,
  output logic [AW-1:0]                mem_wr_addr,
  output logic [asac_pkg::COUNT_W-1:0] mem_wr_data
);
  import asac_pkg::*;

  localparam int CW = (AW > 8) ? AW : 8;

  asac_state_t state_r, state_nxt;

  logic [7:0]         tv_r;
  logic               first_r;
  logic               last_r;
  logic [AW-1:0]      lim_r;
  logic [AW-1:0]      bound_r;
  logic [AW-1:0]      hi_r;
  logic [AW-1:0]      rd_k_r;
  logic [AW-1:0]      rd_pos_r;
  logic               rd_ok_r;
  logic               rdv_r;
  logic [COUNT_W-1:0] o_m1_r;
  logic [COUNT_W-1:0] o_0_r;
  logic               wr_en_r;
  logic [AW-1:0]      wr_addr_r;
  logic [COUNT_W-1:0] wr_data_r;
  logic [COUNT_W-1:0] acc_r;

  logic [CW-1:0]      lim_ext;
  logic [AW-1:0]      lim_start;
  logic [AW-1:0]      bound_start;
  logic               issue;
  logic               emit;
  logic [COUNT_W-1:0] rd_val;
  logic [AW-1:0]      j_w;
  logic               allowed;
  logic [COUNT_W-1:0] new_val;

  // limit saturates to the built row size; entries past the fill mark read zero
  always_comb begin
    lim_ext     = CW'(value_limit);
    lim_start   = (lim_ext > CW'(MAX_VALUE)) ? AW'(MAX_VALUE) : AW'(lim_ext);
    bound_start = (hi_r < lim_start) ? hi_r : lim_start;
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (lim_start == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        if (rd_k_r > lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rdv_r && !wr_en_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // new entry from the three old neighbors as they stream past
  always_comb begin
    rd_val  = rd_ok_r ? mem_rd_data : '0;
    j_w     = rd_pos_r - AW'(1);
    allowed = (tv_r == 8'd0) || (CW'(tv_r) == CW'(j_w));
    if (!allowed) begin
      new_val = '0;
    end else if (first_r) begin
      new_val = COUNT_W'(1);
    end else begin
      new_val = mod_sum3(o_m1_r, o_0_r, rd_val);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      wr_en_r <= 1'b0;
      hi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= issue;
      wr_en_r <= rdv_r && (rd_pos_r >= AW'(2));
      if (state_r == ST_FINISH) begin
        hi_r <= lim_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start && (state_r == ST_IDLE)) begin
      tv_r    <= item.template_value;
      first_r <= item.first_element;
      last_r  <= item.last_element;
      lim_r   <= lim_start;
      bound_r <= bound_start;
      rd_k_r  <= AW'(1);
      acc_r   <= '0;
      o_m1_r  <= '0;
      o_0_r   <= '0;
    end else begin
      if (issue) begin
        rd_k_r   <= rd_k_r + AW'(1);
        rd_pos_r <= rd_k_r;
        rd_ok_r  <= (rd_k_r <= bound_r);
      end
      if (rdv_r) begin
        o_m1_r    <= o_0_r;
        o_0_r     <= rd_val;
        wr_addr_r <= j_w;
        wr_data_r <= new_val;
      end
      if (wr_en_r) begin
        acc_r <= mod_add2(acc_r, wr_data_r);
      end
    end
  end

  assign idle         = (state_r == ST_IDLE);
  assign result.valid = emit;
  assign result.count = acc_r;
  assign mem_rd_en    = issue;
  assign mem_rd_addr  = rd_k_r;
  assign mem_wr_en    = wr_en_r;
  assign mem_wr_addr  = wr_addr_r;
  assign mem_wr_data  = wr_data_r;

endmodule

// ===== hdl/adjacent_step_array_count_dp_unit.sv =====
// top level of the adjacent-step array counter: handshakes, limit register,
// output register; depends on asac_pkg, asac_step_engine, asac_row_mem
//
//   channel  | signals                                         | direction
//   ---------+-------------------------------------------------+----------
//   in       | in_valid/in_ready, template_value, first, last  | to block
//   out      | out_valid/out_ready, array_count                | from block
//   cfg      | cfg_wr_en, cfg_value_limit                      | to block
//
// one beat at a time: the next beat is not taken until the engine is idle again,
// which waits on the walk over the row memory, one entry per cycle on its single
// read port, then the read latency and the write/accumulate drain; a zero limit
// skips the walk. Reset needs no clearing pass: a fill mark tracks how much of the
// row the last beat wrote. A held output beat does not stop the next input beat;
// only a new count waits for the output register.
module adjacent_step_array_count_dp_unit #(
  parameter int MAX_VALUE = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_template_value,
  input  logic                         in_first_element,
  input  logic                         in_last_element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [asac_pkg::COUNT_W-1:0] out_array_count,
  input  logic                         cfg_wr_en,
  input  logic [7:0]                   cfg_value_limit
);
  import asac_pkg::*;

  localparam int DEPTH = MAX_VALUE + 2;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]         cfg_value_limit_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  asac_item_t         item;
  asac_result_t       result;
  logic               eng_idle;
  logic               start;
  logic               slot_free;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [COUNT_W-1:0] mem_rd_data;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [COUNT_W-1:0] mem_wr_data;

  // input beat goes straight to the engine when it is idle
  assign in_ready  = eng_idle;
  assign start     = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    item.template_value = in_template_value;
    item.first_element  = in_first_element;
    item.last_element   = in_last_element;
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_value_limit_r <= VALUE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      cfg_value_limit_r <= cfg_value_limit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_count_r <= result.count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_array_count = out_count_r;

  asac_step_engine #(
    .MAX_VALUE (MAX_VALUE),
    .AW        (AW)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .item        (item),
    .value_limit (cfg_value_limit_r),
    .slot_free   (slot_free),
    .idle        (eng_idle),
    .result      (result),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  asac_row_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

// ===== hdl/asac_checker.sv =====
// port-level checks for the adjacent-step array counter, bound to the top
// depends on asac_pkg and adjacent_step_array_count_dp_unit_defines.svh
`include "adjacent_step_array_count_dp_unit_defines.svh"

module asac_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [asac_pkg::COUNT_W-1:0] out_array_count
);
  import asac_pkg::*;

  // a count is always reduced
  `ASAC_ASSERT_NOW(a_count_reduced, out_valid, out_array_count < COUNT_MOD[COUNT_W-1:0], "count not reduced")

  // one beat at a time: the engine is busy right after taking a beat
  `ASAC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")

  // a fresh count only comes out of a busy engine
  `ASAC_ASSERT_NOW(a_count_from_walk, $rose(out_valid), $past(!in_ready), "count without a walk")

  // stalled output beat holds
  `ASAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_array_count), "output beat dropped")

endmodule

bind adjacent_step_array_count_dp_unit asac_checker u_asac_checker (.*);
